// ===== rtl/core/uwt_pkg.sv =====
`default_nettype none

package uwt_pkg;

	// queue depth must stay a power of two (pointers wrap naturally)
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CHAR_NL  = 8'h0A;
	localparam logic [7:0] CHAR_SP  = 8'h20;
	localparam logic [7:0] CHAR_TAB = 8'h09;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_MARK = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       text_end;
	} text_req_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] token_byte;
		logic       run_last;
	} token_res_t;

	// one classified byte: marker before, data byte, marker after
	typedef struct packed {
		logic       pre;
		logic       dat;
		logic       post;
		logic [7:0] value;
	} entry_t;

	function automatic logic [2:0] char_len(input logic [7:0] lead);
		logic [2:0] len;
		len = 3'd1;
		if ((lead & 8'h80) == 8'h00) len = 3'd1;
		else if ((lead & 8'hE0) == 8'hC0) len = 3'd2;
		else if ((lead & 8'hF0) == 8'hE0) len = 3'd3;
		else if ((lead & 8'hF8) == 8'hF0) len = 3'd4;
		return len;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/uwt_front.sv =====
`default_nettype none

module uwt_front (
	input  logic               clk,
	input  logic               arst_n,
	input  uwt_pkg::text_req_t req,
	input  logic               accept,
	output uwt_pkg::entry_t    entry,
	output logic               push
);
	import uwt_pkg::*;

	logic [1:0] left_q, left_d;
	logic       ideo_q, ideo_d;
	logic       word_q, word_d;
	logic       start, is_nl, is_sp;
	logic [2:0] len, len_m1;
	logic       pre, dat, mid_post, end_post;

	always_comb begin
		start    = (left_q == 2'd0);
		is_nl    = (req.data_byte == CHAR_NL);
		is_sp    = (req.data_byte == CHAR_SP) || (req.data_byte == CHAR_TAB);
		len      = char_len(req.data_byte);
		len_m1   = len - 3'd1;
		left_d   = left_q;
		ideo_d   = ideo_q;
		word_d   = word_q;
		pre      = 1'b0;
		dat      = 1'b1;
		mid_post = 1'b0;
		if (start) begin
			if (is_nl) begin
				pre      = word_q;
				word_d   = 1'b0;
				mid_post = 1'b1;
			end else if (is_sp) begin
				pre    = word_q;
				word_d = 1'b0;
				dat    = 1'b0;
			end else if (len == 3'd3) begin
				pre    = word_q;
				word_d = 1'b0;
				ideo_d = 1'b1;
				left_d = 2'd2;
			end else begin
				word_d = 1'b1;
				ideo_d = 1'b0;
				left_d = len_m1[1:0];
			end
		end else begin
			left_d = left_q - 2'd1;
			if (left_q == 2'd1 && ideo_q) begin
				mid_post = 1'b1;
				ideo_d   = 1'b0;
			end
		end
		// end of text flushes whatever is still open
		end_post = req.text_end && (word_d || ideo_d);
		if (req.text_end) begin
			left_d = 2'd0;
			ideo_d = 1'b0;
			word_d = 1'b0;
		end
		entry.pre   = pre;
		entry.dat   = dat;
		entry.post  = mid_post || end_post;
		entry.value = req.data_byte;
		push        = accept && (pre || dat || mid_post || end_post);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 2'd0;
			ideo_q <= 1'b0;
			word_q <= 1'b0;
		end else if (accept) begin
			left_q <= left_d;
			ideo_q <= ideo_d;
			word_q <= word_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/uwt_queue.sv =====
`default_nettype none

module uwt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  uwt_pkg::entry_t wr,
	input  logic            push,
	input  logic            pop,
	output uwt_pkg::entry_t head,
	output logic            nonempty,
	output logic            full
);
	import uwt_pkg::*;

	entry_t              mem [QDEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QCNT_W-1:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head     = mem[rd_q];
	assign nonempty = (cnt_q != '0);
	assign full     = (cnt_q == QCNT_W'(QDEPTH));

endmodule

`default_nettype wire

// ===== rtl/core/uwt_back.sv =====
`default_nettype none

module uwt_back (
	input  logic                clk,
	input  logic                arst_n,
	input  uwt_pkg::entry_t     head,
	input  logic                head_valid,
	output logic                pop,
	input  logic                out_stall,
	output logic                out_valid,
	output uwt_pkg::token_res_t out_res
);
	import uwt_pkg::*;

	entry_t     cur_q, src, rest;
	logic       cur_valid_q;
	token_res_t res_q, pick;
	logic       valid_q;
	logic       src_ok, load, rest_any;

	always_comb begin
		src    = cur_valid_q ? cur_q : head;
		src_ok = cur_valid_q || head_valid;
		load   = src_ok && (!valid_q || !out_stall);
		rest   = src;
		pick.token_byte = 8'h00;
		if (src.pre) begin
			pick.kind = KIND_MARK;
			rest.pre  = 1'b0;
		end else if (src.dat) begin
			pick.kind       = KIND_DATA;
			pick.token_byte = src.value;
			rest.dat        = 1'b0;
		end else begin
			pick.kind = KIND_MARK;
			rest.post = 1'b0;
		end
		rest_any      = rest.pre || rest.dat || rest.post;
		pick.run_last = !rest_any;
		// leftover pieces of a queue entry park in cur_q
		pop           = load && !cur_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			cur_valid_q <= 1'b0;
		end else begin
			if (load) valid_q <= 1'b1;
			else if (!out_stall) valid_q <= 1'b0;
			if (load) cur_valid_q <= rest_any;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= rest;
			res_q <= pick;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/utf8_word_tokenizer.sv =====
// An accepted byte is queued first; its first result is then registered onto token_req.
// Throughput: one byte per cycle while each byte yields one result and token_stall is low;
// a byte yielding k results emits them one at a time, bursts absorbed by a 4-entry queue.
// text_stall rises only when that queue is full.
// Reset (arst_n low): character state cleared, queue emptied, token_valid low.
`default_nettype none

module utf8_word_tokenizer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                text_valid,
	output logic                text_stall,
	input  uwt_pkg::text_req_t  text_req,
	output logic                token_valid,
	input  logic                token_stall,
	output uwt_pkg::token_res_t token_req
);
	import uwt_pkg::*;

	entry_t fe_entry, q_head;
	logic   fe_push, q_pop, q_nonempty, q_full, accept;

	assign text_stall = q_full;
	assign accept     = text_valid && !q_full;

	uwt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (text_req),
		.accept (accept),
		.entry  (fe_entry),
		.push   (fe_push)
	);

	uwt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (fe_entry),
		.push     (fe_push),
		.pop      (q_pop),
		.head     (q_head),
		.nonempty (q_nonempty),
		.full     (q_full)
	);

	uwt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.head_valid (q_nonempty),
		.pop        (q_pop),
		.out_stall  (token_stall),
		.out_valid  (token_valid),
		.out_res    (token_req)
	);

	a_mark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_req.kind == KIND_MARK |-> token_req.token_byte == 8'h00)
		else $error("end-of-token marker carries a nonzero byte");

	a_no_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_nonempty && !token_valid |=> token_valid)
		else $error("back end idles with work queued");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full && !q_pop |-> !fe_push)
		else $error("queue written while full");

endmodule

`default_nettype wire
